>>> rtl/otp_md4_pkg.sv
// Shared types, constants and lookup functions for the folded MD4 step unit.
// Used by otp_md4_round, otp_md4_seq and otp_md4_fold_step_unit; no dependencies.
`default_nettype none

package otp_md4_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned ROUND_W   = 6;
    localparam int unsigned NUM_STEPS = 48;

    localparam logic [ROUND_W-1:0] LAST_STEP = ROUND_W'(NUM_STEPS - 1);

    localparam logic [WORD_W-1:0] IV_A = 32'h67452301;
    localparam logic [WORD_W-1:0] IV_B = 32'hefcdab89;
    localparam logic [WORD_W-1:0] IV_C = 32'h98badcfe;
    localparam logic [WORD_W-1:0] IV_D = 32'h10325476;

    localparam logic [WORD_W-1:0] PAD_WORD = 32'h00000080;
    localparam logic [WORD_W-1:0] LEN_WORD = 32'd64;

    localparam logic [3:0] WORD_KEY_LO = 4'd0;
    localparam logic [3:0] WORD_KEY_HI = 4'd1;
    localparam logic [3:0] WORD_PAD    = 4'd2;
    localparam logic [3:0] WORD_LEN    = 4'd14;

    localparam logic [1:0] PHASE_F = 2'd0;
    localparam logic [1:0] PHASE_G = 2'd1;
    localparam logic [1:0] PHASE_H = 2'd2;

    typedef struct packed {
        logic               load;
        logic               step;
        logic               finish;
        logic [ROUND_W-1:0] round;
    } ctrl_t;

    function automatic logic [3:0] word_index(input logic [ROUND_W-1:0] idx);
        logic [3:0] sel;
        case (idx[5:4])
            PHASE_F: sel = idx[3:0];
            PHASE_G: sel = {idx[1:0], idx[3:2]};
            default: sel = {idx[0], idx[1], idx[2], idx[3]};
        endcase
        return sel;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [ROUND_W-1:0] idx);
        logic [4:0] s;
        case ({idx[5:4], idx[1:0]})
            4'b0000: s = 5'd3;
            4'b0001: s = 5'd7;
            4'b0010: s = 5'd11;
            4'b0011: s = 5'd19;
            4'b0100: s = 5'd3;
            4'b0101: s = 5'd5;
            4'b0110: s = 5'd9;
            4'b0111: s = 5'd13;
            4'b1000: s = 5'd3;
            4'b1001: s = 5'd9;
            4'b1010: s = 5'd11;
            default: s = 5'd15;
        endcase
        return s;
    endfunction

    function automatic logic [WORD_W-1:0] round_const(input logic [1:0] phase);
        logic [WORD_W-1:0] k;
        case (phase)
            PHASE_F: k = 32'h00000000;
            PHASE_G: k = 32'h5a827999;
            default: k = 32'h6ed9eba1;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

>>> rtl/otp_md4_round.sv
// Shared MD4 step unit: boolean function, four-way add and left rotate.
// Depends on otp_md4_pkg.
`default_nettype none

module otp_md4_round (
    input  wire logic [otp_md4_pkg::WORD_W-1:0]  a,
    input  wire logic [otp_md4_pkg::WORD_W-1:0]  b,
    input  wire logic [otp_md4_pkg::WORD_W-1:0]  c,
    input  wire logic [otp_md4_pkg::WORD_W-1:0]  d,
    input  wire logic [otp_md4_pkg::WORD_W-1:0]  x,
    input  wire logic [otp_md4_pkg::ROUND_W-1:0] idx,
    output logic      [otp_md4_pkg::WORD_W-1:0]  r
);

    logic [otp_md4_pkg::WORD_W-1:0]   f;
    logic [otp_md4_pkg::WORD_W-1:0]   t;
    logic [2*otp_md4_pkg::WORD_W-1:0] dbl;

    always_comb
    begin
        case (idx[5:4])
            otp_md4_pkg::PHASE_F: f = (b & c) | (~b & d);
            otp_md4_pkg::PHASE_G: f = (b & c) | (b & d) | (c & d);
            default:              f = b ^ c ^ d;
        endcase
    end

    assign t   = a + f + x + otp_md4_pkg::round_const(idx[5:4]);
    assign dbl = {t, t} << otp_md4_pkg::rot_amount(idx);
    assign r   = dbl[2*otp_md4_pkg::WORD_W-1:otp_md4_pkg::WORD_W];

endmodule

`default_nettype wire

>>> rtl/otp_md4_seq.sv
// Sequencer for the folded MD4 step unit: step counter and idle/run/finish control.
// Depends on otp_md4_pkg.
`default_nettype none

module otp_md4_seq (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               out_free,
    output logic                    in_stall,
    output otp_md4_pkg::ctrl_t      ctrl
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [otp_md4_pkg::ROUND_W-1:0] round_reg;
    logic [otp_md4_pkg::ROUND_W-1:0] round_next;
    logic                           load;

    assign in_stall = (state_reg != ST_IDLE);
    assign load     = in_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                    round_next = '0;
                end
            end
            ST_RUN:
            begin
                if (round_reg == otp_md4_pkg::LAST_STEP)
                    state_next = ST_FIN;
                else
                    round_next = round_reg + 1'b1;
            end
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
        end
    end

    assign ctrl.load   = load;
    assign ctrl.step   = (state_reg == ST_RUN);
    assign ctrl.finish = (state_reg == ST_FIN) && out_free;
    assign ctrl.round  = round_reg;

    a_last_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && round_reg == otp_md4_pkg::LAST_STEP) |=> (state_reg == ST_FIN))
        else $error("last step did not lead to finish");

    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (state_reg == ST_RUN && round_reg == '0))
        else $error("load did not start at step zero");

    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        round_reg <= otp_md4_pkg::LAST_STEP)
        else $error("step counter out of range");

    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && !out_free) |=> (state_reg == ST_FIN))
        else $error("finish left while output busy");

endmodule

`default_nettype wire

>>> rtl/otp_md4_fold_step_unit.sv
// Top level of the folded MD4 one-time-password step: state words, message hold,
// output register. Depends on otp_md4_pkg, otp_md4_round and otp_md4_seq.
//
//   channel | signals                      | transaction when
//   input   | in_valid, in_stall, key_in   | in_valid && !in_stall
//   output  | out_valid, out_stall, key_out| out_valid && !out_stall
//
// After acceptance an item makes 48 passes through the shared step unit, one per MD4
// step, then adds the initial words and folds once the output register is free.
// in_stall is high from acceptance until the fold is written to the output register.
// A finished result waits in the output register; the next item may start meanwhile,
// and its fold waits while out_stall holds the previous result.
// Reset clears control state only; no memory needs clearing.
`default_nettype none

module otp_md4_fold_step_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] key_in,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      key_out
);

    otp_md4_pkg::ctrl_t ctrl;

    logic [otp_md4_pkg::WORD_W-1:0] a_reg;
    logic [otp_md4_pkg::WORD_W-1:0] b_reg;
    logic [otp_md4_pkg::WORD_W-1:0] c_reg;
    logic [otp_md4_pkg::WORD_W-1:0] d_reg;
    logic [63:0]                    msg_reg;
    logic [63:0]                    key_out_reg;
    logic                           out_valid_reg;
    logic                           out_free;
    logic [otp_md4_pkg::WORD_W-1:0] x_word;
    logic [otp_md4_pkg::WORD_W-1:0] r_word;
    logic [3:0]                     sel;

    assign out_free = !out_valid_reg || !out_stall;

    otp_md4_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .in_stall (in_stall),
        .ctrl     (ctrl)
    );

    assign sel = otp_md4_pkg::word_index(ctrl.round);

    always_comb
    begin
        case (sel)
            otp_md4_pkg::WORD_KEY_LO: x_word = msg_reg[31:0];
            otp_md4_pkg::WORD_KEY_HI: x_word = msg_reg[63:32];
            otp_md4_pkg::WORD_PAD:    x_word = otp_md4_pkg::PAD_WORD;
            otp_md4_pkg::WORD_LEN:    x_word = otp_md4_pkg::LEN_WORD;
            default:                  x_word = '0;
        endcase
    end

    otp_md4_round u_round (
        .a   (a_reg),
        .b   (b_reg),
        .c   (c_reg),
        .d   (d_reg),
        .x   (x_word),
        .idx (ctrl.round),
        .r   (r_word)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            msg_reg <= key_in;
            a_reg   <= otp_md4_pkg::IV_A;
            b_reg   <= otp_md4_pkg::IV_B;
            c_reg   <= otp_md4_pkg::IV_C;
            d_reg   <= otp_md4_pkg::IV_D;
        end
        else if (ctrl.step)
        begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= r_word;
        end
        if (ctrl.finish)
        begin
            key_out_reg[31:0]  <= (a_reg + otp_md4_pkg::IV_A) ^ (c_reg + otp_md4_pkg::IV_C);
            key_out_reg[63:32] <= (b_reg + otp_md4_pkg::IV_B) ^ (d_reg + otp_md4_pkg::IV_D);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.finish)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;
    assign key_out   = key_out_reg;

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.finish |-> out_free)
        else $error("fold written over a pending result");

    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.finish |=> out_valid)
        else $error("fold not presented");

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.step || ctrl.finish) |-> !ctrl.load)
        else $error("load while busy");

endmodule

`default_nettype wire

>>> sim/tb_otp_md4_fold_step_unit.sv
// Self-checking testbench for otp_md4_fold_step_unit: directed and random keys, hash chains,
// checked against a local folded-MD4 model under random input gaps and output stalls.
// Depends on otp_md4_pkg and the RTL of the step unit.
`default_nettype none

module tb_otp_md4_fold_step_unit;

    localparam int unsigned RANDOM_KEYS = 1900;
    localparam int unsigned NUM_DIRECTED = 19;

    // message word read by each of the 48 steps, step 0 in the top nibble
    localparam logic [191:0] MSG_ORDER =
        192'h0123456789abcdef_048c159d26ae37bf_084c2a6e195d3b7f;
    // rotate amounts per phase and step mod 4, first entry in the top byte
    localparam logic [95:0] ROT_TABLE = 96'h03070b13_0305090d_03090b0f;
    localparam logic [31:0] K_MAJ = 32'h5a827999;
    localparam logic [31:0] K_XOR = 32'h6ed9eba1;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [63:0] key_in = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] key_out;

    logic [63:0] expected_folds [$];
    logic [63:0] directed_keys [NUM_DIRECTED] = '{
        64'h0000000000000000, 64'hffffffffffffffff, 64'h0000000000000001,
        64'h8000000000000000, 64'h00000000ffffffff, 64'hffffffff00000000,
        64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 64'h0123456789abcdef,
        64'hfedcba9876543210, 64'h00000000000000ff, 64'hff00000000000000,
        64'h0000000080000000, 64'h0000000100000000, 64'h7fffffffffffffff,
        64'hfffffffffffffffe, 64'h8080808080808080, 64'h0101010101010101,
        64'hdd9904d93461879e
    };

    int unsigned mismatches = 0;
    int unsigned checked_count = 0;
    int unsigned burst_left = 0;
    int unsigned stall_mode = 0;
    int unsigned mode_left = 0;
    int unsigned stall_hold = 0;

    otp_md4_fold_step_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .key_in   (key_in),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .key_out  (key_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(20 * 2_000_000);
        $display("Timeout with %0d results outstanding", expected_folds.size());
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [63:0] md4_fold(input logic [63:0] msg);
        logic [31:0] blk [16];
        logic [31:0] a, b, c, d, f, k, t, r;
        logic [3:0]  widx;
        int          s;
        int          phase;
        for (int j = 0; j < 16; j++)
            blk[j] = '0;
        blk[0]  = msg[31:0];
        blk[1]  = msg[63:32];
        blk[2]  = otp_md4_pkg::PAD_WORD;
        blk[14] = otp_md4_pkg::LEN_WORD;
        a = otp_md4_pkg::IV_A;
        b = otp_md4_pkg::IV_B;
        c = otp_md4_pkg::IV_C;
        d = otp_md4_pkg::IV_D;
        for (int i = 0; i < 48; i++)
        begin
            phase = i / 16;
            case (phase)
                0:
                begin
                    f = (b & c) | (~b & d);
                    k = '0;
                end
                1:
                begin
                    f = (b & c) | (b & d) | (c & d);
                    k = K_MAJ;
                end
                default:
                begin
                    f = b ^ c ^ d;
                    k = K_XOR;
                end
            endcase
            widx = MSG_ORDER[(47 - i) * 4 +: 4];
            s = int'(ROT_TABLE[(11 - (phase * 4 + i % 4)) * 8 +: 8]);
            t = a + f + blk[widx] + k;
            r = (t << s) | (t >> (32 - s));
            a = d;
            d = c;
            c = b;
            b = r;
        end
        a = a + otp_md4_pkg::IV_A;
        b = b + otp_md4_pkg::IV_B;
        c = c + otp_md4_pkg::IV_C;
        d = d + otp_md4_pkg::IV_D;
        return {b ^ d, a ^ c};
    endfunction

    // hold valid and key until the transaction is taken
    task automatic send_key(input logic [63:0] key);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(40, 1);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(60, 20)
                                                      : $urandom_range(12, 1);
        end
        burst_left--;
        in_valid <= 1'b1;
        key_in   <= key;
        do
            @(posedge clk);
        while (in_stall);
        expected_folds.push_back(md4_fold(key));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(3, 0);
                mode_left  = $urandom_range(512, 64);
            end
            else
                mode_left--;
            if (stall_hold > 0)
            begin
                stall_hold--;
                out_stall <= 1'b1;
            end
            else
            begin
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(7, 0) == 0);
                    2: out_stall <= 1'($urandom_range(1, 0));
                    default:
                    begin
                        if ($urandom_range(15, 0) == 0)
                        begin
                            stall_hold = $urandom_range(30, 4);
                            out_stall <= 1'b1;
                        end
                        else
                            out_stall <= 1'b0;
                    end
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        logic [63:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_folds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected transaction: key_out=%h", key_out);
            end
            else
            begin
                want = expected_folds.pop_front();
                checked_count++;
                if (key_out !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch on result %0d: key_out expected %h, got %h",
                                 checked_count, want, key_out);
                end
            end
        end
    end

    initial
    begin
        int unsigned random_count;
        int unsigned chain_count;
        int unsigned pick;
        int unsigned len;
        logic [63:0] key;
        random_count = 0;
        chain_count  = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int row = 0; row < NUM_DIRECTED; row++)
            send_key(directed_keys[row]);

        while (random_count < RANDOM_KEYS)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 60)
            begin
                len = $urandom_range(20, 4);
                key = {$urandom, $urandom};
                repeat (len)
                begin
                    send_key(key);
                    key = md4_fold(key);
                    random_count++;
                    chain_count++;
                end
            end
            else if (pick < 85)
            begin
                send_key({$urandom, $urandom});
                random_count++;
            end
            else
            begin
                case ($urandom_range(2, 0))
                    0: key = 64'd1 << $urandom_range(63, 0);
                    1: key = ~(64'd1 << $urandom_range(63, 0));
                    default: key = {8{8'($urandom)}};
                endcase
                send_key(key);
                random_count++;
            end
        end
        in_valid <= 1'b0;

        while (expected_folds.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("Covered %0d directed and %0d random keys (%0d in hash chains)",
                 NUM_DIRECTED, random_count, chain_count);
        $display("Bursty input, output stalls in four patterns; %0d checked, %0d mismatches",
                 checked_count, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
